// File: design/pske_pkg.sv
// Shared constants for the projected spline kernel evaluator.
// Holds field widths, the Q0.24 kernel table and the fixed scale factors.
// No dependencies.
package pske_pkg;

   // field widths
   localparam int H_W       = 24;   // h_inv, unsigned Q4.20
   localparam int OFS_W     = 24;   // offsets, signed Q12.12
   localparam int VAL_W     = 32;   // kernel value, unsigned Q12.20
   localparam int TENSION_W = 16;   // tension k, unsigned Q0.16

   localparam logic [TENSION_W-1:0] TENSION_RESET = 16'd32517;

   // internal fixed point
   localparam int Q_BITS  = 24;     // fraction bits of weights and u
   localparam int POLY_W  = 28;     // signed width of Catmull-Rom weights
   localparam int TABLE_Q = 24;     // fraction bits of stored table constants

   localparam logic [31:0] EIGHT_OVER_PI_Q30 = 32'd2734261102;

   localparam int TABLE_ENTRIES                = 32;
   localparam int TABLE_FRACTION_BITS_DEFAULT  = 24;
   localparam int IDX_W                        = $clog2(TABLE_ENTRIES);
   localparam int LAST_SEGMENT                 = TABLE_ENTRIES - 3;

   localparam int PIPE_STAGES = 13;

   // projected spline kernel, Q0.24, padded with zero entries at the end
   localparam logic [TABLE_Q-1:0] KERNEL_TABLE [TABLE_ENTRIES] = '{
      24'd15235843, 24'd12582895, 24'd10418836, 24'd8611560,
      24'd7086092,  24'd5800320,  24'd4722551,  24'd3826598,
      24'd3088702,  24'd2485226,  24'd1991488,  24'd1587098,
      24'd1256097,  24'd985821,   24'd766002,   24'd588214,
      24'd445457,   24'd331865,   24'd242493,   24'd173139,
      24'd120220,   24'd80677,    24'd51888,    24'd31611,
      24'd17932,    24'd9225,     24'd4117,     24'd1467,
      24'd346,      24'd30,       24'd0,        24'd0
   };

endpackage

// File: design/projected_spline_kernel_eval_unit.sv
// Projected spline kernel evaluator: 13-stage pipeline, one word in and out per cycle when not stalled.
// A new word may enter every cycle unless req_stall is high. The multiplier stages
// (squares, the 24x24 partial products of the 48x48 product, three Catmull-Rom Horner
// steps, table weighting, scaling) set the depth.
// Synchronous reset empties the pipeline and sets the tension to 32517 (about 0.496).
// Depends on pske_pkg.
module projected_spline_kernel_eval_unit #(
   parameter int TABLE_FRACTION_BITS = pske_pkg::TABLE_FRACTION_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [pske_pkg::H_W-1:0]              req_inv_smoothing,
   input  logic signed [pske_pkg::OFS_W-1:0]     req_offset_x,
   input  logic signed [pske_pkg::OFS_W-1:0]     req_offset_y,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [pske_pkg::VAL_W-1:0]            rsp_kernel_value,
   output logic                                  rsp_saturated,
   input  logic                                  csr_write_enable,
   input  logic [pske_pkg::TENSION_W-1:0]        csr_write_data
);
   import pske_pkg::*;

   localparam int TFB          = TABLE_FRACTION_BITS;
   localparam int ENTRY_SHL    = (TFB >= TABLE_Q) ? TFB - TABLE_Q : 0;
   localparam int ENTRY_SHR    = (TFB >= TABLE_Q) ? 0 : TABLE_Q - TFB;
   localparam int ENTRY_WIDE_W = TABLE_Q + ENTRY_SHL;
   localparam int EPROD_W      = POLY_W + TFB + 1;
   localparam int QPROD_W      = POLY_W + Q_BITS + 2;
   localparam int V_W          = 32 + IDX_W;

   localparam logic signed [POLY_W-1:0]  ONE_Q      = POLY_W'(1) << Q_BITS;
   localparam logic signed [POLY_W-1:0]  THREE_Q    = POLY_W'(3) << Q_BITS;
   localparam logic [Q_BITS:0]           ONE_U      = (Q_BITS+1)'(1) << Q_BITS;
   localparam logic signed [QPROD_W-1:0] Q_ADJ      = (QPROD_W'(1) << Q_BITS) - 1;
   localparam logic signed [EPROD_W-1:0] ENTRY_ADJ  = (EPROD_W'(1) << TFB) - 1;

   // product of a signed weight and an unsigned Q.24 factor, truncated toward zero
   function automatic logic signed [POLY_W-1:0] mul_q(input logic signed [POLY_W-1:0] a,
                                                      input logic [Q_BITS:0] b);
      logic signed [QPROD_W-1:0] p;
      p = a * $signed({1'b0, b});
      if (p < 0) begin
         p = p + Q_ADJ;
      end
      return POLY_W'(p >>> Q_BITS);
   endfunction

   function automatic logic signed [POLY_W-1:0] mul_entry(input logic signed [POLY_W-1:0] w,
                                                          input logic [TFB-1:0] e);
      logic signed [EPROD_W-1:0] p;
      p = w * $signed({1'b0, e});
      if (p < 0) begin
         p = p + ENTRY_ADJ;
      end
      return POLY_W'(p >>> TFB);
   endfunction

   function automatic logic [TFB-1:0] entry_at(input logic [IDX_W-1:0] i);
      logic [ENTRY_WIDE_W-1:0] wide;
      wide = (ENTRY_WIDE_W'(KERNEL_TABLE[i]) << ENTRY_SHL) >> ENTRY_SHR;
      return wide[TFB-1:0];
   endfunction

   // ---------------------------------------------------------------- control
   logic [PIPE_STAGES-1:0] valid_ff, valid_in, stage_ready;
   logic [TENSION_W-1:0]   tension_ff, tension_in;

   // a stage may load when any stage from it to the output is empty, or output moves
   always_comb begin
      for (int i = 0; i < PIPE_STAGES; i++) begin
         stage_ready[i] = !rsp_stall ||
                          ((valid_ff | PIPE_STAGES'((1 << i) - 1)) != '1);
      end
      valid_in[0] = stage_ready[0] ? req_valid : valid_ff[0];
      for (int i = 1; i < PIPE_STAGES; i++) begin
         valid_in[i] = stage_ready[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   assign tension_in = csr_write_enable ? csr_write_data : tension_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         tension_ff <= TENSION_RESET;
      end else begin
         valid_ff   <= valid_in;
         tension_ff <= tension_in;
      end
   end

   assign req_stall = !stage_ready[0];
   assign rsp_valid = valid_ff[PIPE_STAGES-1];

   logic signed [POLY_W-1:0] k_q;
   assign k_q = $signed({{(POLY_W-TENSION_W-8){1'b0}}, tension_ff, 8'b0});

   // ---------------------------------------------------------------- stage 1: squares
   logic [2*H_W-1:0]           s1_h2_in, s1_h2_ff;
   logic signed [2*OFS_W-1:0]  sq_x, sq_y;
   logic [2*OFS_W-2:0]         s1_xx_in, s1_xx_ff, s1_yy_in, s1_yy_ff;

   always_comb begin
      s1_h2_in = req_inv_smoothing * req_inv_smoothing;
      sq_x     = req_offset_x * req_offset_x;
      sq_y     = req_offset_y * req_offset_y;
      s1_xx_in = sq_x[2*OFS_W-2:0];
      s1_yy_in = sq_y[2*OFS_W-2:0];
   end

   // ---------------------------------------------------------------- stage 2: radius squared
   logic [2*H_W-1:0]   s2_h2_in, s2_h2_ff;
   logic [2*OFS_W-1:0] s2_s_in, s2_s_ff;

   always_comb begin
      s2_h2_in = s1_h2_ff;
      s2_s_in  = {1'b0, s1_xx_ff} + {1'b0, s1_yy_ff};
   end

   // ---------------------------------------------------------------- stage 3: partial products
   logic [47:0] s3_p00_in, s3_p00_ff, s3_p10_in, s3_p10_ff;
   logic [47:0] s3_p01_in, s3_p01_ff, s3_p11_in, s3_p11_ff;
   logic [31:0] s3_m_in, s3_m_ff;

   always_comb begin
      s3_p00_in = s2_h2_ff[23:0]  * s2_s_ff[23:0];
      s3_p10_in = s2_h2_ff[47:24] * s2_s_ff[23:0];
      s3_p01_in = s2_h2_ff[23:0]  * s2_s_ff[47:24];
      s3_p11_in = s2_h2_ff[47:24] * s2_s_ff[47:24];
      s3_m_in   = s2_h2_ff[47:16];        // h2 as Q8.24
   end

   // ---------------------------------------------------------------- stage 4: rho^2 and clamp
   logic [95:0] rho2;
   logic        s4_clamp_in, s4_clamp_ff;
   logic [31:0] s4_r32_in, s4_r32_ff, s4_m_in, s4_m_ff;

   always_comb begin
      rho2 = {48'b0, s3_p00_ff}
           + (({48'b0, s3_p10_ff} + {48'b0, s3_p01_ff}) << 24)
           + {s3_p11_ff, 48'b0};
      s4_clamp_in = |rho2[95:64];
      s4_r32_in   = rho2[63:32];
      s4_m_in     = s3_m_ff;
   end

   // ---------------------------------------------------------------- stage 5: index and fraction
   logic [V_W-1:0]    seg_v;
   logic [IDX_W-1:0]  s5_idx_in, s5_idx_ff;
   logic [Q_BITS-1:0] s5_u_in, s5_u_ff;
   logic              s5_clamp_in, s5_clamp_ff;
   logic [31:0]       s5_m_in, s5_m_ff;

   always_comb begin
      seg_v       = V_W'(s4_r32_ff) * V_W'(LAST_SEGMENT);
      s5_idx_in   = seg_v[32 +: IDX_W];
      s5_u_in     = seg_v[31 -: Q_BITS];
      s5_clamp_in = s4_clamp_ff;
      s5_m_in     = s4_m_ff;
   end

   // ---------------------------------------------------------------- stages 6..8: Horner steps
   logic signed [POLY_W-1:0] s6_a_in, s6_a_ff, s6_b_in, s6_b_ff;
   logic signed [POLY_W-1:0] s6_c_in, s6_c_ff, s6_d_in, s6_d_ff;
   logic [Q_BITS-1:0]        s6_u_in, s6_u_ff;
   logic [IDX_W-1:0]         s6_idx_in, s6_idx_ff;
   logic                     s6_clamp_in, s6_clamp_ff;
   logic [31:0]              s6_m_in, s6_m_ff;

   always_comb begin
      s6_a_in     = mul_q(-k_q, {1'b0, s5_u_ff});
      s6_b_in     = mul_q((ONE_Q <<< 1) - k_q, {1'b0, s5_u_ff});
      s6_c_in     = mul_q(k_q - (ONE_Q <<< 1), {1'b0, s5_u_ff});
      // k * (u - 1) formed as -(k * (1 - u)), same truncation toward zero
      s6_d_in     = -mul_q(k_q, ONE_U - {1'b0, s5_u_ff});
      s6_u_in     = s5_u_ff;
      s6_idx_in   = s5_idx_ff;
      s6_clamp_in = s5_clamp_ff;
      s6_m_in     = s5_m_ff;
   end

   logic signed [POLY_W-1:0] s7_a_in, s7_a_ff, s7_b_in, s7_b_ff;
   logic signed [POLY_W-1:0] s7_c_in, s7_c_ff, s7_d_in, s7_d_ff;
   logic [Q_BITS-1:0]        s7_u_in, s7_u_ff;
   logic [IDX_W-1:0]         s7_idx_in, s7_idx_ff;
   logic                     s7_clamp_in, s7_clamp_ff;
   logic [31:0]              s7_m_in, s7_m_ff;

   always_comb begin
      s7_a_in     = mul_q(s6_a_ff + (k_q <<< 1), {1'b0, s6_u_ff});
      s7_b_in     = mul_q(s6_b_ff + k_q - THREE_Q, {1'b0, s6_u_ff});
      s7_c_in     = mul_q(s6_c_ff + THREE_Q - (k_q <<< 1), {1'b0, s6_u_ff});
      s7_d_in     = mul_q(s6_d_ff, {1'b0, s6_u_ff});
      s7_u_in     = s6_u_ff;
      s7_idx_in   = s6_idx_ff;
      s7_clamp_in = s6_clamp_ff;
      s7_m_in     = s6_m_ff;
   end

   logic signed [POLY_W-1:0] s8_a_in, s8_a_ff, s8_b_in, s8_b_ff;
   logic signed [POLY_W-1:0] s8_c_in, s8_c_ff, s8_d_in, s8_d_ff;
   logic [IDX_W-1:0]         s8_idx_in, s8_idx_ff;
   logic                     s8_clamp_in, s8_clamp_ff;
   logic [31:0]              s8_m_in, s8_m_ff;

   always_comb begin
      s8_a_in     = mul_q(s7_a_ff - k_q, {1'b0, s7_u_ff});
      s8_b_in     = mul_q(s7_b_ff, {1'b0, s7_u_ff}) + ONE_Q;
      s8_c_in     = mul_q(s7_c_ff + k_q, {1'b0, s7_u_ff});
      s8_d_in     = mul_q(s7_d_ff, {1'b0, s7_u_ff});
      s8_idx_in   = s7_idx_ff;
      s8_clamp_in = s7_clamp_ff;
      s8_m_in     = s7_m_ff;
   end

   // ---------------------------------------------------------------- stage 9: weight the table
   logic signed [POLY_W-1:0] s9_a_in, s9_a_ff, s9_b_in, s9_b_ff;
   logic signed [POLY_W-1:0] s9_c_in, s9_c_ff, s9_d_in, s9_d_ff;
   logic                     s9_clamp_in, s9_clamp_ff;
   logic [31:0]              s9_m_in, s9_m_ff;

   always_comb begin
      s9_a_in     = mul_entry(s8_a_ff, entry_at(s8_idx_ff));
      s9_b_in     = mul_entry(s8_b_ff, entry_at(IDX_W'(s8_idx_ff + 1)));
      s9_c_in     = mul_entry(s8_c_ff, entry_at(IDX_W'(s8_idx_ff + 2)));
      s9_d_in     = mul_entry(s8_d_ff, entry_at(IDX_W'(s8_idx_ff + 3)));
      s9_clamp_in = s8_clamp_ff;
      s9_m_in     = s8_m_ff;
   end

   // ---------------------------------------------------------------- stage 10: sum, floor at 0
   logic signed [POLY_W+1:0] lin_sum;
   logic [POLY_W:0]          s10_l_in, s10_l_ff;
   logic [31:0]              s10_m_in, s10_m_ff;

   always_comb begin
      lin_sum = (POLY_W+2)'(s9_a_ff) + (POLY_W+2)'(s9_b_ff)
              + (POLY_W+2)'(s9_c_ff) + (POLY_W+2)'(s9_d_ff);
      // clamped radius lands on the padded end entry, which is zero
      if (s9_clamp_ff || lin_sum < 0) begin
         s10_l_in = '0;
      end else begin
         s10_l_in = lin_sum[POLY_W:0];
      end
      s10_m_in = s9_m_ff;
   end

   // ---------------------------------------------------------------- stage 11: times 8/pi
   logic [POLY_W+32:0] g_prod;
   logic [POLY_W+2:0]  s11_g_in, s11_g_ff;
   logic [31:0]        s11_m_in, s11_m_ff;

   always_comb begin
      g_prod   = (POLY_W+33)'(s10_l_ff) * (POLY_W+33)'(EIGHT_OVER_PI_Q30);
      s11_g_in = g_prod[POLY_W+32:30];
      s11_m_in = s10_m_ff;
   end

   // ---------------------------------------------------------------- stage 12: times h^2
   logic [POLY_W+34:0] gm_prod;
   logic [POLY_W+6:0]  s12_r_in, s12_r_ff;

   always_comb begin
      gm_prod  = (POLY_W+35)'(s11_g_ff) * (POLY_W+35)'(s11_m_ff);
      s12_r_in = gm_prod[POLY_W+34:28];
   end

   // ---------------------------------------------------------------- stage 13: saturate, output
   logic [VAL_W-1:0] rsp_kernel_value_in, rsp_kernel_value_ff;
   logic             rsp_saturated_in, rsp_saturated_ff;

   always_comb begin
      rsp_saturated_in    = |s12_r_ff[POLY_W+6:VAL_W];
      rsp_kernel_value_in = rsp_saturated_in ? '1 : s12_r_ff[VAL_W-1:0];
   end

   assign rsp_kernel_value = rsp_kernel_value_ff;
   assign rsp_saturated    = rsp_saturated_ff;

   // ---------------------------------------------------------------- payload registers
   always_ff @(posedge clock) begin
      if (stage_ready[0]) begin
         s1_h2_ff <= s1_h2_in;
         s1_xx_ff <= s1_xx_in;
         s1_yy_ff <= s1_yy_in;
      end
      if (stage_ready[1]) begin
         s2_h2_ff <= s2_h2_in;
         s2_s_ff  <= s2_s_in;
      end
      if (stage_ready[2]) begin
         s3_p00_ff <= s3_p00_in;
         s3_p10_ff <= s3_p10_in;
         s3_p01_ff <= s3_p01_in;
         s3_p11_ff <= s3_p11_in;
         s3_m_ff   <= s3_m_in;
      end
      if (stage_ready[3]) begin
         s4_clamp_ff <= s4_clamp_in;
         s4_r32_ff   <= s4_r32_in;
         s4_m_ff     <= s4_m_in;
      end
      if (stage_ready[4]) begin
         s5_idx_ff   <= s5_idx_in;
         s5_u_ff     <= s5_u_in;
         s5_clamp_ff <= s5_clamp_in;
         s5_m_ff     <= s5_m_in;
      end
      if (stage_ready[5]) begin
         s6_a_ff     <= s6_a_in;
         s6_b_ff     <= s6_b_in;
         s6_c_ff     <= s6_c_in;
         s6_d_ff     <= s6_d_in;
         s6_u_ff     <= s6_u_in;
         s6_idx_ff   <= s6_idx_in;
         s6_clamp_ff <= s6_clamp_in;
         s6_m_ff     <= s6_m_in;
      end
      if (stage_ready[6]) begin
         s7_a_ff     <= s7_a_in;
         s7_b_ff     <= s7_b_in;
         s7_c_ff     <= s7_c_in;
         s7_d_ff     <= s7_d_in;
         s7_u_ff     <= s7_u_in;
         s7_idx_ff   <= s7_idx_in;
         s7_clamp_ff <= s7_clamp_in;
         s7_m_ff     <= s7_m_in;
      end
      if (stage_ready[7]) begin
         s8_a_ff     <= s8_a_in;
         s8_b_ff     <= s8_b_in;
         s8_c_ff     <= s8_c_in;
         s8_d_ff     <= s8_d_in;
         s8_idx_ff   <= s8_idx_in;
         s8_clamp_ff <= s8_clamp_in;
         s8_m_ff     <= s8_m_in;
      end
      if (stage_ready[8]) begin
         s9_a_ff     <= s9_a_in;
         s9_b_ff     <= s9_b_in;
         s9_c_ff     <= s9_c_in;
         s9_d_ff     <= s9_d_in;
         s9_clamp_ff <= s9_clamp_in;
         s9_m_ff     <= s9_m_in;
      end
      if (stage_ready[9]) begin
         s10_l_ff <= s10_l_in;
         s10_m_ff <= s10_m_in;
      end
      if (stage_ready[10]) begin
         s11_g_ff <= s11_g_in;
         s11_m_ff <= s11_m_in;
      end
      if (stage_ready[11]) begin
         s12_r_ff <= s12_r_in;
      end
      if (stage_ready[12]) begin
         rsp_kernel_value_ff <= rsp_kernel_value_in;
         rsp_saturated_ff    <= rsp_saturated_in;
      end
   end

endmodule

// File: design/pske_checker.sv
// Port-level checks for the projected spline kernel evaluator, bound to its top level.
// Depends on pske_pkg and projected_spline_kernel_eval_unit.
module pske_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input logic [pske_pkg::H_W-1:0]           req_inv_smoothing,
   input logic signed [pske_pkg::OFS_W-1:0]  req_offset_x,
   input logic signed [pske_pkg::OFS_W-1:0]  req_offset_y,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic [pske_pkg::VAL_W-1:0]         rsp_kernel_value,
   input logic                               rsp_saturated,
   input logic                               csr_write_enable,
   input logic [pske_pkg::TENSION_W-1:0]     csr_write_data
);
   import pske_pkg::*;

   // reset empties the pipe
   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response word valid straight after reset");

   // input side only stalls when the output word itself is held
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && rsp_stall) |-> !req_stall)
      else $error("request stalled while the output can move");

   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_saturated) |-> (rsp_kernel_value == {VAL_W{1'b1}}))
      else $error("saturated word without maximum value");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_kernel_value) && $stable(rsp_saturated)))
      else $error("stalled response word changed");

endmodule

bind projected_spline_kernel_eval_unit pske_checker u_pske_checker (.*);
